FILE: rtl/core/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

    // sequence space and field widths
    localparam int SEQ_COUNT = 32;
    localparam int SEQ_W     = $clog2(SEQ_COUNT);
    localparam int SEQO_W    = 6;
    localparam int CNT_W     = 9;
    localparam int WIN_W     = 5;
    localparam int ACK_W     = 8;
    localparam int PIDX_W    = 8;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    localparam logic [CNT_W-1:0] TOTAL_RESET  = 9'd1;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load_in;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait until the output register can take the result
                if (!i_status.out_blocked) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/gbn_dp.sv
`default_nettype none

module gbn_dp import gbn_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  wire  [OP_W-1:0]       i_op,
    input  wire  [ACK_W-1:0]      i_ack,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_W-1:0]      i_cfg_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [M_DATA_W-1:0]   o_out_data
);

    logic [CNT_W-1:0]     r_total;
    logic [WIN_W-1:0]     r_win;
    logic [SEQ_COUNT-1:0] r_free;
    logic [SEQ_W-1:0]     r_next;
    logic [SEQ_W-1:0]     r_base;
    logic [CNT_W-1:0]     r_sent;
    logic                 r_finished;
    logic [OP_W-1:0]      r_op;
    logic [ACK_W-1:0]     r_ack;
    logic                 r_out_valid;
    logic [M_DATA_W-1:0]  r_out_data;

    logic [SEQ_COUNT-1:0] n_free;
    logic [SEQ_W-1:0]     n_next;
    logic [SEQ_W-1:0]     n_base;
    logic [CNT_W-1:0]     n_sent;
    logic                 n_finished;
    logic                 n_ok;
    logic [SEQO_W-1:0]    n_seq;
    logic [PIDX_W-1:0]    n_pidx;
    logic                 n_ignored;

    logic [SEQ_W-1:0]     dist_out;
    logic [SEQ_W-1:0]     ack_idx;
    logic [SEQ_W-1:0]     dist_ack;
    logic [SEQ_W-1:0]     last_idx;
    logic [SEQ_W-1:0]     slot_dist;
    logic [SEQ_COUNT-1:0] ack_mask;
    logic [SEQ_COUNT-1:0] tmo_mask;
    logic                 can_send;
    logic                 ack_ok;

    assign o_status.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out_data;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
            r_win   <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOTAL_PACKETS: r_total <= i_cfg_data;
                CFG_WINDOW_SIZE:   r_win   <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_op;
            r_ack <= i_ack;
        end
    end

    assign dist_out = r_next - r_base;
    assign ack_idx  = SEQ_W'(r_ack - ACK_W'(1));
    assign dist_ack = ack_idx - r_base;
    assign last_idx = SEQ_W'(r_total - CNT_W'(1));
    assign ack_ok   = (r_ack != '0) && ({1'b0, r_ack} <= (ACK_W+1)'(SEQ_COUNT));
    assign can_send = (dist_out < r_win) && r_free[r_next] && (r_sent < r_total);

    // wrapped range masks measured from the window base
    always_comb begin
        slot_dist = '0;
        for (int i = 0; i < SEQ_COUNT; i++) begin
            slot_dist   = SEQ_W'(i) - r_base;
            ack_mask[i] = (slot_dist <= dist_ack);
            tmo_mask[i] = (slot_dist < dist_out);
        end
    end

    always_comb begin
        n_free     = r_free;
        n_next     = r_next;
        n_base     = r_base;
        n_sent     = r_sent;
        n_finished = r_finished;
        n_ok       = 1'b0;
        n_seq      = '0;
        n_pidx     = '0;
        n_ignored  = 1'b0;
        case (r_op)
            OP_SEND: begin
                if (can_send) begin
                    n_ok           = 1'b1;
                    n_seq          = SEQO_W'(r_next) + SEQO_W'(1);
                    n_pidx         = r_sent[PIDX_W-1:0];
                    n_free[r_next] = 1'b0;
                    n_next         = r_next + SEQ_W'(1);
                    n_sent         = r_sent + CNT_W'(1);
                end
            end
            OP_ACK: begin
                if (!ack_ok) begin
                    n_ignored = 1'b1;
                end else begin
                    n_free = r_free | ack_mask;
                    n_base = ack_idx + SEQ_W'(1);
                    if ((r_sent >= r_total) && (ack_idx == last_idx)) begin
                        n_finished = 1'b1;
                    end
                end
            end
            OP_TIMEOUT: begin
                n_free = r_free | tmo_mask;
                n_sent = (r_sent > CNT_W'(dist_out)) ? r_sent - CNT_W'(dist_out) : '0;
                n_next = r_base;
            end
            default: ;
        endcase
    end

    // window state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free     <= '1;
            r_next     <= '0;
            r_base     <= '0;
            r_sent     <= '0;
            r_finished <= 1'b0;
        end else if (i_cmd.commit) begin
            r_free     <= n_free;
            r_next     <= n_next;
            r_base     <= n_base;
            r_sent     <= n_sent;
            r_finished <= n_finished;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {2'b00, n_ignored, n_finished, n_base, n_pidx, n_seq, n_ok};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/go_back_n_send_window.sv
`default_nettype none

// go-back-n sender window over a circular space of 32 sequence numbers
//
// input stream: one beat per operation; tuser carries the op (try send, ack,
// timeout), tdata carries the one-based cumulative ack value
// output stream: exactly one result beat per input beat, in order, holding
// the grant (send_ok, seq_out, packet_index), the window base after the
// operation, the sticky all_done flag and the ack_ignored flag
// config port: write total_packets (index 0) or window_size (index 1) with
// i_cfg_we while the block is idle; no read-back
//
// timing: a beat is latched on acceptance; the window state and the output
// register are updated when the controller commits it, once the output can
// take the result; no new beat is taken until the latched one is committed,
// as set by the latch / write-back pair of the two-state controller
// stall: a finished result waits in the output register; the next beat is
// still accepted, and its write-back waits until the waiting result is taken
// reset: synchronous active low; all slots free, base and next sequence at 0,
// no packets sent, total_packets 1, window_size 4, output empty
module go_back_n_send_window import gbn_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire  [S_DATA_W-1:0]   i_s_axis_tdata,   // ack_value[7:0]
    input  wire  [OP_W-1:0]       i_s_axis_tuser,   // op[1:0]
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // send_ok[0], seq_out[6:1], packet_index[14:7], window_base[19:15],
    // all_done[20], ack_ignored[21], zero[23:22]
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_W-1:0]      i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencing: latch a beat, then commit once the output can take it
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // window state, free bitmap, config and output register
    gbn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (i_s_axis_tuser),
        .i_ack       (i_s_axis_tdata[ACK_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // one item in flight: no beat is taken right after one was taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in flight");

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("result overwritten before it was taken");

    // every commit presents a result on the next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_m_axis_tvalid)
        else $error("committed result not presented");

    // a commit only follows a latched beat
    a_commit_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !o_s_axis_tready)
        else $error("commit while idle");

endmodule

`default_nettype wire
